@@ sv/first_fit_bin_packing_core_macros.svh @@
// Assertion macros for the first-fit bin packing core.
`ifndef FIRST_FIT_BIN_PACKING_CORE_MACROS_SVH
`define FIRST_FIT_BIN_PACKING_CORE_MACROS_SVH

`ifndef SYNTH
`define FFBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("first fit core: same-cycle check failed");
`define FFBP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("first fit core: next-cycle check failed");
`else
`define FFBP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FFBP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/ffbp_pkg.sv @@
// Types and constants shared by the first-fit bin packing core.
package ffbp_pkg;

    localparam int MAX_BINS_DEF  = 16;
    localparam int SIZE_BITS_DEF = 16;

    localparam logic [15:0] CAP_RESET = 16'd40;

    localparam logic [1:0] REJ_NONE    = 2'd0;
    localparam logic [1:0] REJ_TOO_BIG = 2'd1;
    localparam logic [1:0] REJ_NO_BIN  = 2'd2;

    typedef struct packed {
        logic [15:0] item_size;
        logic        new_batch;
    } ffbp_in_t;

    typedef struct packed {
        logic [3:0] bin_index;
        logic       opened_bin;
        logic [1:0] rejected;
        logic [4:0] bins_in_use;
    } ffbp_out_t;

endpackage

@@ sv/ffbp_space_mem.sv @@
// Remaining-space memory: one write port, one registered read port.
module ffbp_space_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/first_fit_bin_packing_core.sv @@
// First-fit bin packing core: sequencer, capacity register and result register.
//
// An item is taken when start is high and busy is low. An item larger than the
// bin capacity returns its result in the cycle after acceptance. Otherwise the
// open bins are scanned from bin 0, one bin per cycle through the single read
// port of the remaining-space memory; the scan ends at the first bin that fits
// the item, or after every open bin has been read if none fits. The result is
// on the result port for one cycle, marked by done, and must be taken then; a
// new item may be started in that same cycle. The write to the memory happens
// on the last scan cycle, before any read of the next item, so reads and writes
// of one entry never overlap. Remaining space is valid only for bins below the
// open count and needs no clearing after reset.
module first_fit_bin_packing_core #(
    parameter int MAX_BINS  = ffbp_pkg::MAX_BINS_DEF,
    parameter int SIZE_BITS = ffbp_pkg::SIZE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ffbp_pkg::ffbp_in_t  item,
    output logic                done,
    output ffbp_pkg::ffbp_out_t result,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);

    import ffbp_pkg::*;

`include "first_fit_bin_packing_core_macros.svh"

    localparam int IDX_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [15:0]          cap_reg;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 pend_reg, pend_next;
    logic [IDX_W-1:0]     pend_idx_reg, pend_idx_next;
    logic                 done_reg, done_next;
    ffbp_out_t            result_reg, result_next;

    logic [SIZE_BITS-1:0] cap_w;
    logic [SIZE_BITS-1:0] in_size;
    logic [CNT_W-1:0]     batch_count;
    logic                 hit;
    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_addr;
    logic [SIZE_BITS-1:0] mem_wr_data;
    logic                 mem_rd_en;
    logic [SIZE_BITS-1:0] mem_rd_data;

    ffbp_space_mem #(
        .DEPTH (MAX_BINS),
        .WIDTH (SIZE_BITS)
    ) u_space_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (mem_rd_data)
    );

    assign cap_w       = SIZE_BITS'(cap_reg);
    assign in_size     = SIZE_BITS'(item.item_size);
    assign batch_count = item.new_batch ? '0 : count_reg;
    assign hit         = pend_reg && (mem_rd_data >= size_reg);

    always_comb
    begin
        state_next    = state_reg;
        size_next     = size_reg;
        count_next    = count_reg;
        issue_next    = issue_reg;
        pend_next     = 1'b0;
        pend_idx_next = pend_idx_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = pend_idx_reg;
        mem_wr_data   = mem_rd_data - size_reg;
        mem_rd_en     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    size_next  = in_size;
                    count_next = batch_count;
                    issue_next = '0;
                    if (in_size > cap_w)
                    begin
                        done_next               = 1'b1;
                        result_next.bin_index   = '0;
                        result_next.opened_bin  = 1'b0;
                        result_next.rejected    = REJ_TOO_BIG;
                        result_next.bins_in_use = 5'(batch_count);
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    mem_wr_en               = 1'b1;
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                    result_next.bin_index   = 4'(pend_idx_reg);
                    result_next.opened_bin  = 1'b0;
                    result_next.rejected    = REJ_NONE;
                    result_next.bins_in_use = 5'(count_reg);
                end
                else if (issue_reg != count_reg)
                begin
                    mem_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (count_reg == CNT_W'(MAX_BINS))
                    begin
                        result_next.bin_index   = '0;
                        result_next.opened_bin  = 1'b0;
                        result_next.rejected    = REJ_NO_BIN;
                        result_next.bins_in_use = 5'(count_reg);
                    end
                    else
                    begin
                        mem_wr_en               = 1'b1;
                        mem_wr_addr             = count_reg[IDX_W-1:0];
                        mem_wr_data             = cap_w - size_reg;
                        count_next              = count_reg + 1'b1;
                        result_next.bin_index   = 4'(count_reg);
                        result_next.opened_bin  = 1'b1;
                        result_next.rejected    = REJ_NONE;
                        result_next.bins_in_use = 5'(count_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CAP_RESET;
            count_reg <= '0;
            issue_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg     <= size_next;
        pend_idx_reg <= pend_idx_next;
        result_reg   <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `FFBP_ASSERT_NXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)
    `FFBP_ASSERT_IMP(a_reject_clean, clk, rst_n, done && (result.rejected != REJ_NONE), (result.bin_index == 4'd0) && !result.opened_bin)
    `FFBP_ASSERT_IMP(a_open_counted, clk, rst_n, done && result.opened_bin, result.bins_in_use != 5'd0)
    `FFBP_ASSERT_IMP(a_issue_bound, clk, rst_n, state_reg == ST_SCAN, issue_reg <= count_reg)

endmodule

@@ dv/tb_first_fit_bin_packing_core.sv @@
// Self-checking testbench for the first-fit bin packing core: directed table, then random phases.
`timescale 1ns / 1ps

module tb_first_fit_bin_packing_core;
    import ffbp_pkg::*;

    localparam int MAX_BINS   = MAX_BINS_DEF;
    localparam int LIMIT      = 400000;
    localparam int NUM_STEPS  = 14;
    localparam int NUM_PHASES = 9;
    localparam int PHASE_LEN  = 215;

    typedef struct packed {
        logic        set_cap;
        logic [15:0] cap;
        ffbp_in_t    txn;
        logic [4:0]  reps;
        logic        chk;
        ffbp_out_t   want;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    ffbp_in_t    item = '0;
    logic        done;
    ffbp_out_t   result;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    logic [15:0] space_left [MAX_BINS];
    int          bins_open;
    logic [15:0] capacity_now;
    ffbp_out_t   placements_due [$];
    step_t       steps [NUM_STEPS];
    logic [15:0] phase_caps [NUM_PHASES];
    bit          idle_en;
    int          errors = 0;
    int          cycles = 0;

    first_fit_bin_packing_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("tb_first_fit_bin_packing_core failed");
            $finish;
        end
    end

    function automatic ffbp_out_t place_item(input ffbp_in_t t);
        ffbp_out_t r;
        bit        hit;
        r = '0;
        r.rejected = REJ_NONE;
        hit = 1'b0;
        if (t.new_batch)
            bins_open = 0;
        if (t.item_size > capacity_now)
            r.rejected = REJ_TOO_BIG;
        else
        begin
            for (int i = 0; i < bins_open && !hit; i++)
            begin
                if (space_left[i] >= t.item_size)
                begin
                    hit = 1'b1;
                    space_left[i] = space_left[i] - t.item_size;
                    r.bin_index = 4'(i);
                end
            end
            if (!hit)
            begin
                if (bins_open >= MAX_BINS)
                    r.rejected = REJ_NO_BIN;
                else
                begin
                    r.bin_index = 4'(bins_open);
                    space_left[bins_open] = capacity_now - t.item_size;
                    bins_open++;
                    r.opened_bin = 1'b1;
                end
            end
        end
        r.bins_in_use = 5'(bins_open);
        return r;
    endfunction

    function automatic ffbp_in_t random_item(input logic [15:0] cap);
        ffbp_in_t t;
        t.new_batch = ($urandom_range(0, 39) == 0);
        case ($urandom_range(0, 9))
            0, 1: t.item_size = 16'($urandom());
            2: t.item_size = cap;
            3: t.item_size = cap + 16'd1;
            4: t.item_size = '0;
            default: t.item_size = 16'($urandom_range(0, 32'(cap) >> $urandom_range(0, 3)));
        endcase
        return t;
    endfunction

    task automatic report_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (placements_due.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, got %h", $time, result);
                errors++;
            end
            else
            begin
                ffbp_out_t want;
                want = placements_due.pop_front();
                report_field("bin_index", 16'(want.bin_index), 16'(result.bin_index));
                report_field("opened_bin", 16'(want.opened_bin), 16'(result.opened_bin));
                report_field("rejected", 16'(want.rejected), 16'(result.rejected));
                report_field("bins_in_use", 16'(want.bins_in_use), 16'(result.bins_in_use));
            end
        end
    end

    task automatic send_item(input ffbp_in_t t, output ffbp_out_t predicted);
        int gap;
        gap = 0;
        while (idle_en && $urandom_range(0, 99) < 37)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= t;
        do
            @(posedge clk);
        while (busy);
        predicted = place_item(t);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (placements_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [15:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        capacity_now = v;
    endtask

    initial
    begin
        ffbp_out_t predicted;
        steps = '{
            '{1'b0, 16'd0,     '{16'd41,    1'b0}, 5'd1,  1'b1, '{4'd0, 1'b0, REJ_TOO_BIG, 5'd0}},
            '{1'b0, 16'd0,     '{16'd0,     1'b0}, 5'd1,  1'b1, '{4'd0, 1'b1, REJ_NONE,    5'd1}},
            '{1'b0, 16'd0,     '{16'd40,    1'b0}, 5'd1,  1'b1, '{4'd0, 1'b0, REJ_NONE,    5'd1}},
            '{1'b0, 16'd0,     '{16'd40,    1'b0}, 5'd1,  1'b1, '{4'd1, 1'b1, REJ_NONE,    5'd2}},
            '{1'b0, 16'd0,     '{16'd0,     1'b0}, 5'd1,  1'b1, '{4'd0, 1'b0, REJ_NONE,    5'd2}},
            '{1'b0, 16'd0,     '{16'd65535, 1'b0}, 5'd1,  1'b1, '{4'd0, 1'b0, REJ_TOO_BIG, 5'd2}},
            '{1'b0, 16'd0,     '{16'd40,    1'b0}, 5'd14, 1'b0, '{4'd0, 1'b0, REJ_NONE,    5'd0}},
            '{1'b0, 16'd0,     '{16'd40,    1'b0}, 5'd1,  1'b1, '{4'd0, 1'b0, REJ_NO_BIN,  5'd16}},
            '{1'b1, 16'd0,     '{16'd0,     1'b1}, 5'd1,  1'b1, '{4'd0, 1'b1, REJ_NONE,    5'd1}},
            '{1'b0, 16'd0,     '{16'd1,     1'b0}, 5'd1,  1'b1, '{4'd0, 1'b0, REJ_TOO_BIG, 5'd1}},
            '{1'b1, 16'd65535, '{16'd10,    1'b1}, 5'd1,  1'b1, '{4'd0, 1'b1, REJ_NONE,    5'd1}},
            '{1'b1, 16'd100,   '{16'd200,   1'b0}, 5'd1,  1'b1, '{4'd0, 1'b0, REJ_TOO_BIG, 5'd1}},
            '{1'b0, 16'd0,     '{16'd100,   1'b0}, 5'd1,  1'b1, '{4'd0, 1'b0, REJ_NONE,    5'd1}},
            '{1'b1, 16'd65535, '{16'd65535, 1'b0}, 5'd1,  1'b1, '{4'd1, 1'b1, REJ_NONE,    5'd2}}
        };
        phase_caps = '{16'd65535, CAP_RESET, 16'd1, 16'd0, 16'd1000, 16'd65535,
                       16'($urandom_range(1, 65535)), 16'd7, 16'($urandom_range(2, 300))};
        bins_open    = 0;
        capacity_now = CAP_RESET;
        idle_en      = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[s])
        begin
            if (steps[s].set_cap)
            begin
                drain();
                write_capacity(steps[s].cap);
            end
            for (int n = 0; n < steps[s].reps; n++)
            begin
                send_item(steps[s].txn, predicted);
                placements_due.push_back(steps[s].chk ? steps[s].want : predicted);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain();
            write_capacity(phase_caps[p]);
            idle_en = (p != 5);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                send_item(random_item(capacity_now), predicted);
                placements_due.push_back(predicted);
            end
        end

        start <= 1'b0;
        while (placements_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0 && placements_due.size() == 0)
            $display("tb_first_fit_bin_packing_core passed");
        else
            $display("tb_first_fit_bin_packing_core failed");
        $finish;
    end
endmodule
